@@ rtl/core/hdtb_pkg.sv @@
// ----------------------------------------------------------------------------
// hdtb_pkg
// Shared types and character codes for the hex dump text to bytes block.
// ----------------------------------------------------------------------------
package hdtb_pkg;

    // Request kinds on the text channel
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Character codes
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_W     = 8'h57;

    // One queue entry: one or two bytes to send, in order
    typedef struct packed {
        logic       pair;
        logic [7:0] first;
        logic [7:0] second;
    } hdtb_entry_t;

endpackage

@@ rtl/core/hdtb_text_if.sv @@
// ----------------------------------------------------------------------------
// hdtb_text_if
// Valid/ready channel carrying one text character or an end of input mark.
// ----------------------------------------------------------------------------
interface hdtb_text_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_code;

    modport source (output valid, output req_type, output char_code, input ready);
    modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

@@ rtl/core/hdtb_byte_if.sv @@
// ----------------------------------------------------------------------------
// hdtb_byte_if
// Valid/ready channel carrying one rebuilt byte and its last-of-run flag.
// ----------------------------------------------------------------------------
interface hdtb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

@@ rtl/core/hdtb_front.sv @@
// ----------------------------------------------------------------------------
// hdtb_front
// Classifies each character, keeps the token and line state, and pushes the
// bytes each item gives into the queue as one entry.
// ----------------------------------------------------------------------------
module hdtb_front
    import hdtb_pkg::*;
#(
    parameter int TOKEN_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    hdtb_text_if.sink    text,
    input  logic         q_full,
    output logic         q_push,
    output hdtb_entry_t  q_entry
);

    logic [TOKEN_BITS-1:0] token_acc_reg, token_acc_next;
    logic                  seen_space_reg, seen_space_next;
    logic                  prev_was_sep_reg, prev_was_sep_next;
    logic [7:0]            held_high_reg, held_high_next;
    logic                  have_held_reg, have_held_next;
    logic                  count_odd_reg, count_odd_next;

    logic                  accept;
    logic                  is_end;
    logic                  is_sep;
    logic [TOKEN_BITS-1:0] char_wide;
    logic [TOKEN_BITS-1:0] digit_off;
    logic [TOKEN_BITS-1:0] acc_shifted;

    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;
    assign is_end     = (text.req_type == REQ_END) || (text.char_code == CHR_NUL);
    assign is_sep     = (text.char_code == CHR_SPACE) || (text.char_code == CHR_NL);

    // Offset wraps at the token width, so non-digits still add something
    assign char_wide   = TOKEN_BITS'(text.char_code);
    assign digit_off   = (text.char_code <= CHR_NINE) ? char_wide - TOKEN_BITS'(CHR_ZERO)
                                                      : char_wide - TOKEN_BITS'(CHR_W);
    assign acc_shifted = seen_space_reg ? (token_acc_reg << 4) : (token_acc_reg << 3);

    always_comb
    begin
        token_acc_next    = token_acc_reg;
        seen_space_next   = seen_space_reg;
        prev_was_sep_next = prev_was_sep_reg;
        held_high_next    = held_high_reg;
        have_held_next    = have_held_reg;
        count_odd_next    = count_odd_reg;
        q_push            = 1'b0;
        q_entry           = '0;
        if (accept)
        begin
            if (is_end)
            begin
                // Drop the held byte when the last count was odd
                if (have_held_reg && !count_odd_reg)
                begin
                    q_push        = 1'b1;
                    q_entry.first = held_high_reg;
                end
                token_acc_next    = '0;
                seen_space_next   = 1'b0;
                prev_was_sep_next = 1'b1;
                held_high_next    = '0;
                have_held_next    = 1'b0;
                count_odd_next    = 1'b0;
            end
            else if (is_sep)
            begin
                if (!prev_was_sep_reg)
                begin
                    if (seen_space_reg)
                    begin
                        q_push = 1'b1;
                        if (have_held_reg)
                        begin
                            q_entry.pair   = 1'b1;
                            q_entry.first  = held_high_reg;
                            q_entry.second = token_acc_reg[7:0];
                        end
                        else
                        begin
                            q_entry.first = token_acc_reg[7:0];
                        end
                        held_high_next = token_acc_reg[15:8];
                        have_held_next = 1'b1;
                    end
                    else
                    begin
                        count_odd_next = token_acc_reg[0];
                    end
                end
                seen_space_next   = (text.char_code == CHR_SPACE);
                token_acc_next    = '0;
                prev_was_sep_next = 1'b1;
            end
            else
            begin
                token_acc_next    = acc_shifted + digit_off;
                prev_was_sep_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_acc_reg    <= '0;
            seen_space_reg   <= 1'b0;
            prev_was_sep_reg <= 1'b1;
            held_high_reg    <= '0;
            have_held_reg    <= 1'b0;
            count_odd_reg    <= 1'b0;
        end
        else
        begin
            token_acc_reg    <= token_acc_next;
            seen_space_reg   <= seen_space_next;
            prev_was_sep_reg <= prev_was_sep_next;
            held_high_reg    <= held_high_next;
            have_held_reg    <= have_held_next;
            count_odd_reg    <= count_odd_next;
        end
    end

endmodule

@@ rtl/core/hdtb_queue.sv @@
// ----------------------------------------------------------------------------
// hdtb_queue
// Small register FIFO of byte entries between the front and the back.
// ----------------------------------------------------------------------------
module hdtb_queue
    import hdtb_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  hdtb_entry_t  push_entry,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output hdtb_entry_t  head
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    hdtb_entry_t         slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/core/hdtb_back.sv @@
// ----------------------------------------------------------------------------
// hdtb_back
// Takes entries from the queue and sends their bytes one per cycle, while
// data.ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module hdtb_back
    import hdtb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_not_empty,
    input  hdtb_entry_t  q_head,
    output logic         q_pop,
    hdtb_byte_if.source  data
);

    logic       valid_reg, valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       run_last_reg, run_last_next;
    logic       second_reg, second_next;
    logic       load;

    assign data.valid    = valid_reg;
    assign data.out_byte = out_byte_reg;
    assign data.run_last = run_last_reg;

    // Refill the output stage when it is empty or being taken
    assign load = !valid_reg || data.ready;

    always_comb
    begin
        valid_next    = valid_reg && !data.ready;
        out_byte_next = out_byte_reg;
        run_last_next = run_last_reg;
        second_next   = second_reg;
        q_pop         = 1'b0;
        if (load && q_not_empty)
        begin
            valid_next = 1'b1;
            if (second_reg)
            begin
                out_byte_next = q_head.second;
                run_last_next = 1'b1;
                second_next   = 1'b0;
                q_pop         = 1'b1;
            end
            else
            begin
                out_byte_next = q_head.first;
                run_last_next = !q_head.pair;
                second_next   = q_head.pair;
                q_pop         = !q_head.pair;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

endmodule

@@ rtl/core/hex_dump_text_to_bytes.sv @@
// ----------------------------------------------------------------------------
// hex_dump_text_to_bytes
// Rebuilds a byte stream from the text of a hex word dump.
// ----------------------------------------------------------------------------
// Usage:
//   text : one character per item (req_type 0), or an end of input mark
//          (req_type 1; a NUL character acts the same). Each line starts
//          with an octal count whose parity is kept; later tokens are hex
//          words, sent low byte first, high byte one word later.
//   data : rebuilt bytes, run_last set on the last byte an item gives.
//   An item is taken every cycle while the queue has room. Bytes leave
//   one per cycle while data.ready is high, so an item giving two bytes
//   holds the port for both; the output port rate sets the sustained figure.
//   An accepted item is written to the queue, then to the output register.
//   When data stalls, the output register holds its byte and the queue
//   fills; text.ready drops once the queue is full.
//   Reset clears the line state (as if after a newline), drops any held
//   byte and empties the queue. End of input sends the held high byte only
//   when the last count was even, then returns to the reset state.
// ----------------------------------------------------------------------------
module hex_dump_text_to_bytes
    import hdtb_pkg::*;
#(
    parameter int TOKEN_BITS  = 16,
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    hdtb_text_if.sink    text,
    hdtb_byte_if.source  data
);

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_not_empty;
    hdtb_entry_t q_entry;
    hdtb_entry_t q_head;

    hdtb_front #(
        .TOKEN_BITS (TOKEN_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    hdtb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    hdtb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .data        (data)
    );

endmodule
